// ----- design/u2da_pkg.sv -----
// ----------------------------------------------------------------------------
// u2da_pkg: shared types and constants for the decimal ascii converter
// Holds field widths, the bcd layout, length-modifier flag positions and
// the sequencer state type.
// ----------------------------------------------------------------------------
package u2da_pkg;

    // transaction field widths
    localparam int VALUE_W    = 64;
    localparam int FLAGS_W    = 6;
    localparam int CHAR_W     = 6;
    localparam int COUNT_W    = 32;

    // bcd working register: enough digits for any 64-bit value
    localparam int BCD_DIGITS = 20;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
    localparam int LEFT_W     = $clog2(BCD_DIGITS + 1);

    // shift-add-3 conversion, several input bits per cycle
    localparam int STEP_BITS  = 4;
    localparam int CONV_STEPS = VALUE_W / STEP_BITS;
    localparam int STEP_CNT_W = $clog2(CONV_STEPS);

    // length-modifier flag positions, lowest set bit wins
    localparam int FLAG_HH    = 0;
    localparam int FLAG_H     = 1;
    localparam int FLAG_LL    = 2;
    localparam int FLAG_Z     = 5;

    // truncation widths picked by the flags
    localparam int CUT_HH_W   = 8;
    localparam int CUT_H_W    = 16;
    localparam int CUT_NONE_W = 32;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } t_state;

endpackage

// ----- design/u2da_if.sv -----
// ----------------------------------------------------------------------------
// u2da_if: valid/ready channels of the decimal ascii converter
// Input channel carries the value and modifier flags, output channel one
// ascii digit per transaction.
// ----------------------------------------------------------------------------
interface u2da_in_if import u2da_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [VALUE_W-1:0]   value;
    logic [FLAGS_W-1:0]   modifier_flags;

    modport source (output valid, output value, output modifier_flags, input ready);
    modport sink   (input valid, input value, input modifier_flags, output ready);
endinterface

interface u2da_out_if import u2da_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CHAR_W-1:0]    digit_char;
    logic                 is_last;
    logic [COUNT_W-1:0]   chars_total;

    modport source (output valid, output digit_char, output is_last, output chars_total,
                    input ready);
    modport sink   (input valid, input digit_char, input is_last, input chars_total,
                    output ready);
endinterface

// ----- design/u2da_dabble.sv -----
// ----------------------------------------------------------------------------
// u2da_dabble: one step of the shift-add-3 binary to bcd unit
// Shifts STEP_BITS binary bits into the bcd register, correcting each digit
// that would overflow before every single-bit shift.
// ----------------------------------------------------------------------------
module u2da_dabble import u2da_pkg::*; (
    input  logic [BCD_W-1:0]     i_bcd,
    input  logic [STEP_BITS-1:0] i_bits,
    output logic [BCD_W-1:0]     o_bcd
);

    // add 3 to every digit of five or more, then shift one bit in, msb first
    always_comb begin
        logic [BCD_W-1:0] v;
        v = i_bcd;
        for (int s = 0; s < STEP_BITS; s++) begin
            for (int d = 0; d < BCD_DIGITS; d++) begin
                if (v[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                    v[d*DIGIT_W +: DIGIT_W] = v[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
                end
            end
            v = {v[BCD_W-2:0], i_bits[STEP_BITS-1-s]};
        end
        o_bcd = v;
    end

endmodule

// ----- design/unsigned_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// unsigned_to_decimal_ascii: unsigned value to decimal ascii digit stream
// Truncates a 64-bit value by its length-modifier flags and sends its
// decimal digits as ascii, most significant first, no leading zeros.
// ----------------------------------------------------------------------------
// Usage:
// - i_in (valid/ready) takes a value and its modifier flags; the lowest set
//   flag picks the width: hh 8 bits, h 16 bits, ll/l/j/z 64 bits, none 32.
// - o_out (valid/ready) gives one transaction per digit, is_last on the
//   final one, chars_total as a saturating count of digits since reset, this one included.
// - i_in.ready is high only while the converter is idle; one value at a time.
// - Steps per value: accept, conversion in the shared shift-add-3 unit
//   (4 bits per cycle over 64 bits), dropping each leading zero digit,
//   a move into the send phase, then sending each digit, held while the
//   receiver stalls. Dropped and sent digits always cover all 20 bcd
//   positions.
// - A stalled receiver simply holds the current digit; nothing is lost.
// - Synchronous reset clears the sequencer and the character count to zero.
// ----------------------------------------------------------------------------
module unsigned_to_decimal_ascii import u2da_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u2da_in_if.sink     i_in,
    u2da_out_if.source  o_out
);

    t_state                r_state, n_state;
    logic [VALUE_W-1:0]    r_bin,   n_bin;
    logic [BCD_W-1:0]      r_bcd,   n_bcd;
    logic [STEP_CNT_W-1:0] r_step,  n_step;
    logic [LEFT_W-1:0]     r_left,  n_left;
    logic [COUNT_W-1:0]    r_count, n_count;

    logic [VALUE_W-1:0]    w_cut;
    logic [BCD_W-1:0]      w_dabble;
    logic [COUNT_W-1:0]    w_count_inc;
    logic [DIGIT_W-1:0]    w_top_digit;
    logic                  w_in_fire;
    logic                  w_out_fire;

    assign w_in_fire   = i_in.valid && i_in.ready;
    assign w_out_fire  = o_out.valid && o_out.ready;
    assign w_top_digit = r_bcd[BCD_W-1 -: DIGIT_W];
    assign w_count_inc = (r_count == COUNT_MAX) ? COUNT_MAX : r_count + COUNT_W'(1);

    // truncate by the lowest set modifier flag
    always_comb begin
        if (i_in.modifier_flags[FLAG_HH]) begin
            w_cut = {{(VALUE_W-CUT_HH_W){1'b0}}, i_in.value[CUT_HH_W-1:0]};
        end else if (i_in.modifier_flags[FLAG_H]) begin
            w_cut = {{(VALUE_W-CUT_H_W){1'b0}}, i_in.value[CUT_H_W-1:0]};
        end else if (|i_in.modifier_flags[FLAG_Z:FLAG_LL]) begin
            w_cut = i_in.value;
        end else begin
            w_cut = {{(VALUE_W-CUT_NONE_W){1'b0}}, i_in.value[CUT_NONE_W-1:0]};
        end
    end

    // shared shift-add-3 unit
    u2da_dabble u_dabble (
        .i_bcd  (r_bcd),
        .i_bits (r_bin[VALUE_W-1 -: STEP_BITS]),
        .o_bcd  (w_dabble)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) n_state = ST_CONV;
            end
            ST_CONV: begin
                if (r_step == STEP_CNT_W'(CONV_STEPS - 1)) n_state = ST_SKIP;
            end
            ST_SKIP: begin
                if (!(w_top_digit == '0 && r_left > LEFT_W'(1))) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_fire && r_left == LEFT_W'(1)) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and counters
    always_comb begin
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_step  = r_step;
        n_left  = r_left;
        n_count = r_count;
        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    n_bin  = w_cut;
                    n_bcd  = '0;
                    n_step = '0;
                    n_left = LEFT_W'(BCD_DIGITS);
                end
            end
            ST_CONV: begin
                n_bcd  = w_dabble;
                n_bin  = {r_bin[VALUE_W-STEP_BITS-1:0], {STEP_BITS{1'b0}}};
                n_step = r_step + STEP_CNT_W'(1);
            end
            ST_SKIP: begin
                if (w_top_digit == '0 && r_left > LEFT_W'(1)) begin
                    n_bcd  = {r_bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    n_left = r_left - LEFT_W'(1);
                end
            end
            ST_EMIT: begin
                if (w_out_fire) begin
                    n_bcd   = {r_bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    n_left  = r_left - LEFT_W'(1);
                    n_count = w_count_inc;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_left  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_left  <= n_left;
            r_count <= n_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    // handshake and output payload
    always_comb begin
        i_in.ready        = (r_state == ST_IDLE);
        o_out.valid       = (r_state == ST_EMIT);
        o_out.digit_char  = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, w_top_digit};
        o_out.is_last     = (r_left == LEFT_W'(1));
        o_out.chars_total = w_count_inc;
    end

endmodule
